@@ hdl/bbe_pkg.sv @@
// ============================================================================
// bbe_pkg
// Shared widths, command codes and word-ALU operations for the bit-set bank.
// ============================================================================
`default_nettype none

package bbe_pkg;

    localparam int CMD_W   = 4;
    localparam int SET_W   = 3;
    localparam int ELEM_W  = 10;
    localparam int VALUE_W = 11;

    localparam logic [CMD_W-1:0] CMD_PUT       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_TEST      = 4'd2;
    localparam logic [CMD_W-1:0] CMD_COUNT     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_UNION     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_INTERSECT = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DIFF      = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_COPY      = 4'd8;

    typedef enum logic [2:0] {
        ALU_KEEP,
        ALU_SET,
        ALU_CLR,
        ALU_OR,
        ALU_AND,
        ALU_ANDN,
        ALU_ZERO,
        ALU_COPY
    } alu_op_t;

endpackage

`default_nettype wire

@@ hdl/bbe_ram.sv @@
// ============================================================================
// bbe_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module bbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/bbe_word_alu.sv @@
// ============================================================================
// bbe_word_alu
// Per-word bit operation and population count.
// ============================================================================
`default_nettype none

module bbe_word_alu #(
    parameter int WORD_BITS = 32,
    parameter int POP_W     = 6
) (
    input  wire bbe_pkg::alu_op_t   op,
    input  wire logic [WORD_BITS-1:0] a,
    input  wire logic [WORD_BITS-1:0] b,
    input  wire logic [WORD_BITS-1:0] mask,
    output logic      [WORD_BITS-1:0] y,
    output logic      [POP_W-1:0]     pop
);

    always_comb
    begin
        unique case (op)
            bbe_pkg::ALU_KEEP: y = a;
            bbe_pkg::ALU_SET:  y = a | mask;
            bbe_pkg::ALU_CLR:  y = a & ~mask;
            bbe_pkg::ALU_OR:   y = a | b;
            bbe_pkg::ALU_AND:  y = a & b;
            bbe_pkg::ALU_ANDN: y = a & ~b;
            bbe_pkg::ALU_ZERO: y = '0;
            bbe_pkg::ALU_COPY: y = b;
            default:           y = a;
        endcase
    end

    assign pop = POP_W'($countones(a));

endmodule

`default_nettype wire

@@ hdl/bitset_bank_engine_top.sv @@
// ============================================================================
// bitset_bank_engine_top
// Bank of bit sets in word memory; bit, count, clear, copy and merge commands.
// ============================================================================
// A command word is taken when start is high and busy is low; exactly one
// result comes back on value, marked by done for a single cycle, and must be
// captured then since the block cannot be held off. Put, delete and test pass
// through the divide, address, bit-read and bit-write states. Count, union,
// intersect, difference, clear and copy walk every word of the set one word
// per cycle through the memory read port. After reset a clearing pass writes
// zero to all NUM_SETS * WORDS_PER_SET words with busy held high.
// ============================================================================
`default_nettype none

module bitset_bank_engine_top #(
    parameter int NUM_SETS     = 8,
    parameter int SET_CAPACITY = 1024,
    parameter int WORD_BITS    = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [bbe_pkg::CMD_W-1:0]     cmd,
    input  wire logic [bbe_pkg::SET_W-1:0]     set_a,
    input  wire logic [bbe_pkg::SET_W-1:0]     set_b,
    input  wire logic [bbe_pkg::ELEM_W-1:0]    element,
    output logic                               done,
    output logic      [bbe_pkg::VALUE_W-1:0]   value
);

    localparam int WPS     = (SET_CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH   = NUM_SETS * WPS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WIDX_W  = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int BO_W    = $clog2(WORD_BITS);
    localparam int POP_W   = $clog2(WORD_BITS + 1);
    localparam int ACC_W   = $clog2(WPS * WORD_BITS + 1);
    localparam int EW      = bbe_pkg::ELEM_W;
    // element / WORD_BITS by reciprocal; estimate is exact or one low
    localparam int SH      = 20;
    localparam int RECIP   = (1 << SH) / WORD_BITS;

    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WPS - 1);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DIV,
        S_ADDR,
        S_BIT_RD,
        S_BIT_WR,
        S_WALK,
        S_FIN
    } state_t;

    state_t                     state_reg;
    logic [bbe_pkg::CMD_W-1:0]  cmd_reg;
    logic [bbe_pkg::SET_W-1:0]  seta_reg;
    logic [bbe_pkg::SET_W-1:0]  setb_reg;
    logic [EW-1:0]              elem_reg;
    logic [EW-1:0]              q_reg;
    logic [EW-1:0]              widx_reg;
    logic [BO_W-1:0]            boff_reg;
    logic [AW-1:0]              abase_reg;
    logic [AW-1:0]              bbase_reg;
    logic [AW-1:0]              init_reg;
    logic [WIDX_W-1:0]          idx_reg;
    logic                       issue_reg;
    logic                       pv_reg;
    logic [WIDX_W-1:0]          pidx_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic                       done_reg;
    logic [bbe_pkg::VALUE_W-1:0] value_reg;

    logic [31:0]          prod;
    logic [31:0]          qw;
    logic [31:0]          rem;
    logic [31:0]          abase_w;
    logic [31:0]          bbase_w;
    logic [31:0]          bit_addr_w;
    logic [31:0]          rd_a_w;
    logic [31:0]          rd_b_w;
    logic [31:0]          wr_walk_w;
    logic [31:0]          acc_w;
    logic                 a_ok;
    logic                 b_ok;
    logic                 e_ok;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        raddr_a;
    logic [AW-1:0]        raddr_b;
    logic [WORD_BITS-1:0] rdata_a;
    logic [WORD_BITS-1:0] rdata_b;

    bbe_pkg::alu_op_t     alu_op;
    logic [WORD_BITS-1:0] alu_mask;
    logic [WORD_BITS-1:0] alu_y;
    logic [POP_W-1:0]     alu_pop;

    // two copies of the store so A and B words can be read in the same cycle
    bbe_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH), .AW(AW)) u_ram_a (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    bbe_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH), .AW(AW)) u_ram_b (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    bbe_word_alu #(.WORD_BITS(WORD_BITS), .POP_W(POP_W)) u_alu (
        .op   (alu_op),
        .a    (rdata_a),
        .b    (rdata_b),
        .mask (alu_mask),
        .y    (alu_y),
        .pop  (alu_pop)
    );

    // decode arithmetic
    assign prod    = 32'(elem_reg) * 32'(RECIP);
    assign qw      = 32'(q_reg) * 32'(WORD_BITS);
    assign rem     = 32'(elem_reg) - qw;
    assign abase_w = 32'(seta_reg) * 32'(WPS);
    assign bbase_w = 32'(setb_reg) * 32'(WPS);
    assign a_ok    = 32'(seta_reg) < 32'(NUM_SETS);
    assign b_ok    = 32'(setb_reg) < 32'(NUM_SETS);
    assign e_ok    = 32'(elem_reg) < 32'(SET_CAPACITY);

    assign bit_addr_w = 32'(abase_reg) + 32'(widx_reg);
    assign rd_a_w     = 32'(abase_reg) + 32'(idx_reg);
    assign rd_b_w     = 32'(bbase_reg) + 32'(idx_reg);
    assign wr_walk_w  = 32'(abase_reg) + 32'(pidx_reg);
    assign acc_w      = 32'(acc_reg);

    assign alu_mask = WORD_BITS'(1) << boff_reg;

    always_comb
    begin
        raddr_a   = (state_reg == S_BIT_RD) ? bit_addr_w[AW-1:0] : rd_a_w[AW-1:0];
        raddr_b   = rd_b_w[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = wr_walk_w[AW-1:0];
        ram_wdata = alu_y;
        alu_op    = bbe_pkg::ALU_KEEP;

        unique case (cmd_reg)
            bbe_pkg::CMD_PUT:       alu_op = bbe_pkg::ALU_SET;
            bbe_pkg::CMD_DELETE:    alu_op = bbe_pkg::ALU_CLR;
            bbe_pkg::CMD_UNION:     alu_op = bbe_pkg::ALU_OR;
            bbe_pkg::CMD_INTERSECT: alu_op = bbe_pkg::ALU_AND;
            bbe_pkg::CMD_DIFF:      alu_op = bbe_pkg::ALU_ANDN;
            bbe_pkg::CMD_CLEAR:     alu_op = bbe_pkg::ALU_ZERO;
            bbe_pkg::CMD_COPY:      alu_op = bbe_pkg::ALU_COPY;
            default:                alu_op = bbe_pkg::ALU_KEEP;
        endcase

        priority if (state_reg == S_INIT)
        begin
            ram_we    = 1'b1;
            ram_waddr = init_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_BIT_WR)
        begin
            ram_waddr = bit_addr_w[AW-1:0];
            ram_we    = (cmd_reg == bbe_pkg::CMD_PUT) || (cmd_reg == bbe_pkg::CMD_DELETE);
        end
        else if (pv_reg)
        begin
            ram_we = (cmd_reg != bbe_pkg::CMD_COUNT);
        end
        else
        begin
            ram_we = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cmd_reg   <= '0;
            seta_reg  <= '0;
            setb_reg  <= '0;
            elem_reg  <= '0;
            q_reg     <= '0;
            widx_reg  <= '0;
            boff_reg  <= '0;
            abase_reg <= '0;
            bbase_reg <= '0;
            init_reg  <= '0;
            idx_reg   <= '0;
            issue_reg <= 1'b0;
            pv_reg    <= 1'b0;
            pidx_reg  <= '0;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
            value_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + AW'(1);
                    if (init_reg == LAST_ADDR)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    // done is only ever raised on the way back to idle
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        seta_reg  <= set_a;
                        setb_reg  <= set_b;
                        elem_reg  <= element;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    q_reg     <= prod[SH+EW-1:SH];
                    state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    if (rem >= 32'(WORD_BITS))
                    begin
                        widx_reg <= q_reg + EW'(1);
                        boff_reg <= BO_W'(rem - 32'(WORD_BITS));
                    end
                    else
                    begin
                        widx_reg <= q_reg;
                        boff_reg <= BO_W'(rem);
                    end
                    abase_reg <= abase_w[AW-1:0];
                    bbase_reg <= bbase_w[AW-1:0];
                    idx_reg   <= '0;
                    issue_reg <= 1'b1;
                    pv_reg    <= 1'b0;
                    acc_reg   <= '0;
                    if (!a_ok)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        unique case (cmd_reg)
                            bbe_pkg::CMD_PUT, bbe_pkg::CMD_DELETE, bbe_pkg::CMD_TEST:
                                state_reg <= e_ok ? S_BIT_RD : S_FIN;
                            bbe_pkg::CMD_COUNT, bbe_pkg::CMD_CLEAR:
                                state_reg <= S_WALK;
                            bbe_pkg::CMD_UNION, bbe_pkg::CMD_INTERSECT,
                            bbe_pkg::CMD_DIFF, bbe_pkg::CMD_COPY:
                                state_reg <= b_ok ? S_WALK : S_FIN;
                            default:
                                state_reg <= S_FIN;
                        endcase
                    end
                end
                S_BIT_RD:
                begin
                    state_reg <= S_BIT_WR;
                end
                S_BIT_WR:
                begin
                    done_reg  <= 1'b1;
                    value_reg <= (cmd_reg == bbe_pkg::CMD_TEST) ?
                                 bbe_pkg::VALUE_W'(rdata_a[boff_reg]) : '0;
                    state_reg <= S_IDLE;
                end
                S_WALK:
                begin
                    // read of word idx overlaps write-back of word pidx
                    pv_reg   <= issue_reg;
                    pidx_reg <= idx_reg;
                    if (pv_reg)
                    begin
                        acc_reg <= acc_reg + ACC_W'(alu_pop);
                    end
                    if (issue_reg)
                    begin
                        idx_reg <= idx_reg + WIDX_W'(1);
                        if (idx_reg == LAST_WORD)
                        begin
                            issue_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    pv_reg    <= 1'b0;
                    done_reg  <= 1'b1;
                    value_reg <= (cmd_reg == bbe_pkg::CMD_COUNT) ?
                                 acc_w[bbe_pkg::VALUE_W-1:0] : '0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign value = value_reg;

endmodule

`default_nettype wire
